### hw/rtl/json_string_escaper_utf8_check_unit_assert.svh
// Assertion macros for the JSON string escaper.
// Included by the RTL modules that carry concurrent checks; needs clk_i and rst_ni in scope.
`ifndef JSON_STRING_ESCAPER_UTF8_CHECK_UNIT_ASSERT_SVH
`define JSON_STRING_ESCAPER_UTF8_CHECK_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define JSE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define JSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/jse_pkg.sv
// Shared types, constants and byte classification for the JSON string escaper.
// No dependencies; imported by jse_emit and the top level.
package jse_pkg;

  // Emission mode of one token (a source byte and how it is written out)
  typedef enum logic [1:0] {
    TK_NONE,
    TK_RAW,
    TK_ESC,
    TK_HEX
  } tok_mode_e;

  typedef struct packed {
    tok_mode_e   mode;
    logic [7:0]  data;
  } tok_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  localparam int unsigned HeldDepth = 3;
  localparam logic [2:0]  EscLastSub = 3'd1;
  localparam logic [2:0]  HexLastSub = 3'd5;

  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  // Total UTF-8 sequence length for a lead byte, zero if not a valid lead
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b inside {[8'hc2:8'hdf]}) len = 3'd2;
    else if (b inside {[8'he0:8'hef]}) len = 3'd3;
    else if (b inside {[8'hf0:8'hf4]}) len = 3'd4;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] b);
    return (b & 8'hc0) == 8'h80;
  endfunction

  // Strict range of the second byte, narrowed for the overlong, surrogate and out-of-range leads
  function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
    logic ok;
    case (lead)
      8'he0:   ok = b inside {[8'ha0:8'hbf]};
      8'hed:   ok = b inside {[8'h80:8'h9f]};
      8'hf0:   ok = b inside {[8'h90:8'hbf]};
      8'hf4:   ok = b inside {[8'h80:8'h8f]};
      default: ok = is_cont(b);
    endcase
    return ok;
  endfunction

  // How a byte is handled with nothing held; TK_NONE means it starts a hold
  function automatic tok_t fresh_tok(input logic [7:0] b, input logic eos);
    tok_t t;
    t.data = b;
    t.mode = TK_RAW;
    case (b)
      8'h22: begin t.mode = TK_ESC; t.data = CH_QUOTE;  end
      8'h5c: begin t.mode = TK_ESC; t.data = CH_BSLASH; end
      8'h08: begin t.mode = TK_ESC; t.data = CH_B;      end
      8'h0c: begin t.mode = TK_ESC; t.data = CH_F;      end
      8'h0a: begin t.mode = TK_ESC; t.data = CH_N;      end
      8'h0d: begin t.mode = TK_ESC; t.data = CH_R;      end
      8'h09: begin t.mode = TK_ESC; t.data = CH_T;      end
      default: begin
        if (b < 8'h20) t.mode = TK_HEX;
        else if (b < 8'h80) t.mode = TK_RAW;
        else if (seq_len(b) == 3'd0 || eos) t.mode = TK_HEX;
        else t.mode = TK_NONE;
      end
    endcase
    return t;
  endfunction

endpackage

### hw/rtl/jse_emit.sv
// Shared byte formatter: turns one token and a sub-step count into one output byte.
// Depends on jse_pkg.
module jse_emit (
  input  jse_pkg::tok_t tok_i,
  input  logic [2:0]    sub_i,
  output logic [7:0]    byte_o,
  output logic          tok_end_o
);
  import jse_pkg::*;

  // Raw byte, two-byte short escape or six-byte \u00XX escape
  always_comb begin
    byte_o    = tok_i.data;
    tok_end_o = 1'b1;
    case (tok_i.mode)
      TK_RAW: begin
        byte_o    = tok_i.data;
        tok_end_o = 1'b1;
      end
      TK_ESC: begin
        byte_o    = (sub_i == 3'd0) ? CH_BSLASH : tok_i.data;
        tok_end_o = (sub_i == EscLastSub);
      end
      TK_HEX: begin
        case (sub_i)
          3'd0:    byte_o = CH_BSLASH;
          3'd1:    byte_o = CH_U;
          3'd2:    byte_o = CH_ZERO;
          3'd3:    byte_o = CH_ZERO;
          3'd4:    byte_o = HEX_DIGITS[tok_i.data[7:4]];
          default: byte_o = HEX_DIGITS[tok_i.data[3:0]];
        endcase
        tok_end_o = (sub_i == HexLastSub);
      end
      default: begin
        byte_o    = 8'h00;
        tok_end_o = 1'b1;
      end
    endcase
  end

endmodule

### hw/rtl/json_string_escaper_utf8_check_unit.sv
// Top level of the JSON string escaper with strict UTF-8 checking.
// Depends on jse_pkg, jse_emit and json_string_escaper_utf8_check_unit_assert.svh.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+--------------------------------------
//   in      | sink      | in_valid_i / in_stall_o   | in_byte_i, end_of_string_i
//   out     | source    | out_valid_o / out_stall_i | out_byte_o, run_last_o, string_done_o
//
// An input word is taken while the unit is idle; it then emits 0 to 24 output words, one per cycle
// through the shared formatter while out is free.
// A word that only starts or extends a held UTF-8 sequence emits nothing.
// in_stall_o is high while the sequencer emits; out stalls freeze the sequencer.
// Reset clears the held count and the sequencer; the held bytes themselves are not reset.
module json_string_escaper_utf8_check_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       string_done_o
);
  import jse_pkg::*;

  state_e      state_q, state_d;
  logic [1:0]  held_cnt_q, held_cnt_d;
  logic [7:0]  held_q [HeldDepth];
  logic [7:0]  tok_q [HeldDepth];
  logic [1:0]  ntok_q, ntok_d;
  logic        held_hex_q, held_hex_d;
  tok_t        cur_q, cur_d;
  logic        eos_q, eos_d;
  logic [1:0]  idx_q, idx_d;
  logic [2:0]  sub_q, sub_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q;
  logic        out_last_q, out_done_q;

  logic        in_acc, start, adv, last;
  logic        held_we;
  logic [1:0]  held_wa;
  logic [2:0]  len, cnt_ext;
  logic        ok, complete, extend;
  tok_t        fr, tok;
  logic [7:0]  emit_byte;
  logic        tok_end;

  // Input decode against the held sequence
  assign in_acc  = in_valid_i && !in_stall_o;
  assign len     = seq_len(held_q[0]);
  assign cnt_ext = {1'b0, held_cnt_q} + 3'd1;
  assign ok      = (held_cnt_q == 2'd1) ? second_ok(held_q[0], in_byte_i) : is_cont(in_byte_i);
  assign complete = (held_cnt_q != 2'd0) && ok && (cnt_ext == len);
  assign extend   = (held_cnt_q != 2'd0) && ok && !end_of_string_i && (cnt_ext < len)
                    && (held_cnt_q != 2'd3);
  assign fr = fresh_tok(in_byte_i, end_of_string_i);

  // Token under emission: held bytes first, then the current byte
  always_comb begin
    if (idx_q < ntok_q) begin
      tok.mode = held_hex_q ? TK_HEX : TK_RAW;
      tok.data = tok_q[idx_q];
    end else begin
      tok = cur_q;
    end
  end

  jse_emit u_emit (
    .tok_i     (tok),
    .sub_i     (sub_q),
    .byte_o    (emit_byte),
    .tok_end_o (tok_end)
  );

  // Last word of this item: end of the current token, or of the last held one when
  // the current byte starts a new hold
  always_comb begin
    if (idx_q >= ntok_q) last = tok_end;
    else last = tok_end && (idx_q == ntok_q - 2'd1) && (cur_q.mode == TK_NONE);
  end

  // FSM outputs
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    adv        = (state_q == ST_RUN) && (!out_valid_q || !out_stall_i);
  end

  // Accept decision: what to emit and how the hold changes
  always_comb begin
    start      = 1'b0;
    held_cnt_d = held_cnt_q;
    held_we    = 1'b0;
    held_wa    = 2'd0;
    ntok_d     = ntok_q;
    held_hex_d = held_hex_q;
    cur_d      = cur_q;
    eos_d      = eos_q;
    if (in_acc) begin
      eos_d = end_of_string_i;
      if (held_cnt_q == 2'd0) begin
        ntok_d     = 2'd0;
        held_hex_d = 1'b0;
        cur_d      = fr;
        if (fr.mode == TK_NONE) begin
          held_we    = 1'b1;
          held_cnt_d = 2'd1;
        end else begin
          start = 1'b1;
        end
      end else if (complete) begin
        start      = 1'b1;
        ntok_d     = held_cnt_q;
        held_hex_d = 1'b0;
        cur_d.mode = TK_RAW;
        cur_d.data = in_byte_i;
        held_cnt_d = 2'd0;
      end else if (extend) begin
        held_we    = 1'b1;
        held_wa    = held_cnt_q;
        held_cnt_d = held_cnt_q + 2'd1;
      end else begin
        // mismatch or early end: hex-escape the hold, then handle this byte afresh
        start      = 1'b1;
        ntok_d     = held_cnt_q;
        held_hex_d = 1'b1;
        cur_d      = fr;
        if (fr.mode == TK_NONE) begin
          held_we    = 1'b1;
          held_cnt_d = 2'd1;
        end else begin
          held_cnt_d = 2'd0;
        end
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (start) state_d = ST_RUN;
      ST_RUN:  if (adv && last) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer counters and output register control
  always_comb begin
    idx_d       = idx_q;
    sub_d       = sub_q;
    out_valid_d = out_valid_q;
    if (start) begin
      idx_d = 2'd0;
      sub_d = 3'd0;
    end else if (adv && !last) begin
      if (tok_end) begin
        idx_d = idx_q + 2'd1;
        sub_d = 3'd0;
      end else begin
        sub_d = sub_q + 3'd1;
      end
    end
    if (adv) out_valid_d = 1'b1;
    else if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      held_cnt_q  <= 2'd0;
      idx_q       <= 2'd0;
      sub_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_cnt_q  <= held_cnt_d;
      idx_q       <= idx_d;
      sub_q       <= sub_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (held_we) held_q[held_wa] <= in_byte_i;
    if (start) tok_q <= held_q;
    ntok_q     <= ntok_d;
    held_hex_q <= held_hex_d;
    cur_q      <= cur_d;
    eos_q      <= eos_d;
    if (adv) begin
      out_byte_q <= emit_byte;
      out_last_q <= last;
      out_done_q <= last && eos_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign run_last_o    = out_last_q;
  assign string_done_o = out_done_q;

`include "json_string_escaper_utf8_check_unit_assert.svh"

  // End of string always empties the hold and always emits at least one word
  `JSE_ASSERT_NEXT(a_eos_clears_hold, in_acc && end_of_string_i, held_cnt_q == 2'd0, "hold not empty after end of string")
  `JSE_ASSERT_NEXT(a_eos_emits, in_acc && end_of_string_i, state_q == ST_RUN, "end of string produced no output")
  // A nonempty hold always starts with a valid lead and is shorter than its sequence
  `JSE_ASSERT_NOW(a_hold_valid, held_cnt_q != 2'd0, (len != 3'd0) && ({1'b0, held_cnt_q} < len), "held sequence inconsistent")
  // string_done only rides on the last word of an item
  `JSE_ASSERT_NOW(a_done_is_last, out_valid_o && string_done_o, run_last_o, "string_done without run_last")

endmodule
